// ===== rtl/lcdsw_pkg.sv =====
// lcdsw_pkg: shared types and constants for the two-line lcd scroll writer
// used by lcdsw_nibble_tx and lcd_two_line_scroll_writer_unit; no dependencies
`timescale 1ns / 1ps

package lcdsw_pkg;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_LINE_ONE = 8'h80;
    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_TAB     = 8'h09;
    localparam logic [7:0] CODE_SPACE   = 8'h20;
    // a zero character ends the message early
    localparam logic [7:0] CODE_END     = 8'h00;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // one byte handed from the sequencer to the nibble sender
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } t_seq_state;

    // which byte of the sequence is on the bus
    typedef enum logic [2:0] {
        PH_CLEAR,
        PH_HOME,
        PH_LINE,
        PH_LINE2,
        PH_CHAR
    } t_phase;

endpackage

// ===== rtl/lcd_two_line_scroll_writer_unit.sv =====
// lcd_two_line_scroll_writer_unit: message sequencer for a 4-bit character lcd
// depends on lcdsw_pkg, lcdsw_line_ram and lcdsw_nibble_tx
//
// channel | dir | tdata              | tuser                    | tlast
// s       | in  | [7:0] char_code    | [0] char_valid [1] first | -
// m       | out | [3:0] nibble       | [0] reg_select           | last
//
// each byte goes out on the bus as two nibbles, high then low; a replayed
// character is first read from the line ram in ST_FETCH. a message start sends
// clear, line one, the stored previous line, line two, then its character if any.
// o_s_tready is high only while the sequencer is idle. reset is synchronous,
// active low, and empties the stored line. stalls on i_m_tready hold the nibble.
`timescale 1ns / 1ps

module lcd_two_line_scroll_writer_unit
    import lcdsw_pkg::*;
#(
    parameter int LINE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic [1:0] i_s_tuser,   // [0] char_valid, [1] first
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [3:0] nibble, [7:4] zero
    output logic       o_m_tuser,   // [0] reg_select
    output logic       o_m_tlast
);

    localparam int IDX_W = $clog2(LINE_WIDTH);
    localparam int LEN_W = $clog2(LINE_WIDTH + 1);

    t_seq_state r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_prev_len, n_prev_len;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic             r_stopped, n_stopped;
    logic             r_has_char, n_has_char;
    logic [7:0]       r_char, n_char;

    logic             w_load;
    t_byte_req        w_req;
    logic             w_done;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic [7:0]       w_rd_data;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;

    logic             w_accept;
    logic             w_start;
    logic             w_take;
    logic             w_emit;
    logic             w_halt;
    logic             w_stop_eff;
    logic [LEN_W-1:0] w_cur_eff;
    logic [LEN_W-1:0] w_idx_inc;
    logic [7:0]       w_mapped;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // decode of the incoming item against the running message
    always_comb begin
        w_start    = i_s_tuser[1];
        w_stop_eff = w_start ? 1'b0 : r_stopped;
        w_cur_eff  = w_start ? '0 : r_cur_len;
        w_take     = i_s_tuser[0] && !w_stop_eff;
        w_emit     = w_take && (i_s_tdata != CODE_END) && (w_cur_eff < LEN_W'(LINE_WIDTH));
        w_halt     = w_take && !w_emit;
        w_mapped   = ((i_s_tdata == CODE_NEWLINE) || (i_s_tdata == CODE_TAB)) ?
                     CODE_SPACE : i_s_tdata;
        w_idx_inc  = LEN_W'(r_idx) + LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_CLEAR;
            r_idx      <= '0;
            r_prev_len <= '0;
            r_cur_len  <= '0;
            r_stopped  <= 1'b0;
            r_has_char <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_prev_len <= n_prev_len;
            r_cur_len  <= n_cur_len;
            r_stopped  <= n_stopped;
            r_has_char <= n_has_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_prev_len = r_prev_len;
        n_cur_len  = r_cur_len;
        n_stopped  = r_stopped;
        n_has_char = r_has_char;
        n_char     = r_char;
        w_load     = 1'b0;
        w_req      = '{rs: RS_CMD, data: CMD_CLEAR, last: 1'b0};
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx;
        w_wr_en    = 1'b0;
        w_wr_addr  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_stopped  = w_stop_eff | w_halt;
                    n_cur_len  = w_emit ? (w_cur_eff + LEN_W'(1)) : w_cur_eff;
                    n_has_char = w_emit;
                    n_char     = w_mapped;
                    if (w_start) begin
                        n_prev_len = r_cur_len;
                        w_load     = 1'b1;
                        w_req      = '{rs: RS_CMD, data: CMD_CLEAR, last: 1'b0};
                        n_phase    = PH_CLEAR;
                        n_state    = ST_SEND;
                    end else if (w_emit) begin
                        w_load    = 1'b1;
                        w_req     = '{rs: RS_DATA, data: w_mapped, last: 1'b1};
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_cur_len[IDX_W-1:0];
                        n_phase   = PH_CHAR;
                        n_state   = ST_SEND;
                    end
                end
            end
            ST_FETCH: begin
                w_load  = 1'b1;
                w_req   = '{rs: RS_DATA, data: w_rd_data, last: 1'b0};
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (w_done) begin
                    unique case (r_phase)
                        PH_CLEAR: begin
                            w_load  = 1'b1;
                            w_req   = '{rs: RS_CMD, data: CMD_LINE_ONE, last: 1'b0};
                            n_phase = PH_HOME;
                        end
                        PH_HOME: begin
                            if (r_prev_len != '0) begin
                                n_idx     = '0;
                                w_rd_en   = 1'b1;
                                w_rd_addr = '0;
                                n_phase   = PH_LINE;
                                n_state   = ST_FETCH;
                            end else begin
                                w_load  = 1'b1;
                                w_req   = '{rs: RS_CMD, data: CMD_LINE_TWO,
                                            last: !r_has_char};
                                n_phase = PH_LINE2;
                            end
                        end
                        PH_LINE: begin
                            if (w_idx_inc < r_prev_len) begin
                                n_idx     = w_idx_inc[IDX_W-1:0];
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_idx_inc[IDX_W-1:0];
                                n_state   = ST_FETCH;
                            end else begin
                                w_load  = 1'b1;
                                w_req   = '{rs: RS_CMD, data: CMD_LINE_TWO,
                                            last: !r_has_char};
                                n_phase = PH_LINE2;
                            end
                        end
                        PH_LINE2: begin
                            if (r_has_char) begin
                                // replay is done, so slot zero may now be overwritten
                                w_load    = 1'b1;
                                w_req     = '{rs: RS_DATA, data: r_char, last: 1'b1};
                                w_wr_en   = 1'b1;
                                w_wr_addr = '0;
                                n_phase   = PH_CHAR;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        PH_CHAR: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    lcdsw_line_ram #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(n_char),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    lcdsw_nibble_tx u_nibble_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_req     (w_req),
        .o_done    (w_done),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

endmodule

// ===== rtl/lcdsw_line_ram.sv =====
// lcdsw_line_ram: single-port-write, registered-read store for the previous line
// depends on nothing but its LINE_WIDTH parameter
`timescale 1ns / 1ps

module lcdsw_line_ram #(
    parameter int LINE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] i_rd_addr,
    output logic [7:0]                    o_rd_data
);

    logic [7:0] r_mem [LINE_WIDTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lcdsw_nibble_tx.sv =====
// lcdsw_nibble_tx: shared byte-to-nibble sender, high nibble then low nibble
// depends on lcdsw_pkg (t_byte_req)
`timescale 1ns / 1ps

module lcdsw_nibble_tx
    import lcdsw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_byte_req i_req,
    output logic      o_done,
    output logic      o_m_tvalid,
    input  logic      i_m_tready,
    output logic [7:0] o_m_tdata,   // [3:0] nibble, [7:4] zero
    output logic      o_m_tuser,    // [0] reg_select
    output logic      o_m_tlast
);

    logic      r_valid;
    logic      r_half;
    t_byte_req r_req;
    logic      w_take;

    assign w_take = r_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_half  <= 1'b0;
        end else if (w_take) begin
            r_half <= ~r_half;
            if (r_half) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
        end
    end

    assign o_done     = w_take && r_half;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'b0000, (r_half ? r_req.data[3:0] : r_req.data[7:4])};
    assign o_m_tuser  = r_req.rs;
    // only the low nibble of the final byte closes the request
    assign o_m_tlast  = r_req.last && r_half;

endmodule

// ===== tb/testbench.sv =====
// testbench: checks lcd_two_line_scroll_writer_unit nibble by nibble against its own predictor
// depends on lcdsw_pkg and the rtl of the unit; directed messages then random ones, random idling
`timescale 1ns / 1ps

import lcdsw_pkg::*;

localparam int LINE_W = 16;

typedef struct packed {
    logic [7:0] code;
    logic       valid;
    logic       first;
} t_lcd_request;

typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
} t_lcd_nibble;

class lcd_nibble_scoreboard;
    t_lcd_nibble pending_nibbles[$];
    logic [7:0]  stored_line[LINE_W];
    logic [4:0]  line_len;
    logic        halted;
    int          errors;

    function new();
        line_len = '0;
        halted   = 1'b0;
        errors   = 0;
    endfunction

    function void push_byte(logic rs, logic [7:0] value);
        pending_nibbles.push_back('{rs: rs, nib: value[7:4], last: 1'b0});
        pending_nibbles.push_back('{rs: rs, nib: value[3:0], last: 1'b0});
    endfunction

    // returns the number of nibbles this request is expected to cause
    function int note_request(t_lcd_request req);
        int          n0;
        logic [4:0]  replay_len;
        logic [7:0]  ch;
        t_lcd_nibble tail;
        n0 = pending_nibbles.size();
        if (req.first) begin
            replay_len = line_len;
            push_byte(RS_CMD, CMD_CLEAR);
            push_byte(RS_CMD, CMD_LINE_ONE);
            for (int i = 0; i < replay_len; i++) begin
                push_byte(RS_DATA, stored_line[i]);
            end
            push_byte(RS_CMD, CMD_LINE_TWO);
            line_len = '0;
            halted   = 1'b0;
        end
        if (req.valid && !halted) begin
            if (req.code == CODE_END || line_len >= LINE_W) begin
                halted = 1'b1;
            end else begin
                ch = (req.code == CODE_NEWLINE || req.code == CODE_TAB) ? CODE_SPACE : req.code;
                stored_line[line_len[3:0]] = ch;
                line_len = line_len + 5'd1;
                push_byte(RS_DATA, ch);
            end
        end
        if (pending_nibbles.size() > n0) begin
            tail = pending_nibbles.pop_back();
            tail.last = 1'b1;
            pending_nibbles.push_back(tail);
        end
        return pending_nibbles.size() - n0;
    endfunction

    task report_mismatch(string what);
        if (errors < 50) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        errors++;
    endtask

    task check_nibble(logic [7:0] tdata, logic rs, logic last);
        t_lcd_nibble want;
        if (pending_nibbles.size() == 0) begin
            report_mismatch($sformatf("nibble %h with nothing expected", tdata));
            return;
        end
        want = pending_nibbles.pop_front();
        if (tdata !== {4'h0, want.nib}) begin
            report_mismatch($sformatf("tdata %h, expected %h", tdata, {4'h0, want.nib}));
        end
        if (rs !== want.rs) begin
            report_mismatch($sformatf("reg_select %b, expected %b", rs, want.rs));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
        end
    endtask

    function int pending();
        return pending_nibbles.size();
    endfunction
endclass

module testbench;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] char_code
    logic [1:0] i_s_tuser;   // [0] char_valid, [1] first
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [3:0] nibble, [7:4] zero
    logic       o_m_tuser;   // [0] reg_select
    logic       o_m_tlast;

    lcd_nibble_scoreboard sb;
    bit steady_flow;
    int productive_requests;

    lcd_two_line_scroll_writer_unit #(
        .LINE_WIDTH(LINE_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 5);
    endfunction

    task send_request(logic [7:0] code, logic valid, logic first);
        int gap;
        int produced;
        t_lcd_request req;
        gap = draw_gap();
        req = '{code: code, valid: valid, first: first};
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = req.code;
        i_s_tuser  = {req.first, req.valid};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        produced = sb.note_request(req);
        if (produced > 0) begin
            productive_requests++;
        end
    endtask

    function logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
            return CODE_END;
        end else if (pick == 1) begin
            return CODE_NEWLINE;
        end else if (pick == 2) begin
            return CODE_TAB;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // receiving side: one stall draw per nibble, check on each accepted nibble
    initial begin
        int gap;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            repeat (gap) begin
                @(negedge i_clk);
                i_m_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            sb.check_nibble(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    initial begin
        int len;
        bit empty_start;
        sb = new();
        steady_flow = 1'b0;
        productive_requests = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // characters before any start, with newline and tab turned into spaces
        send_request(8'h41, 1'b1, 1'b0);
        send_request(CODE_NEWLINE, 1'b1, 1'b0);
        send_request(CODE_TAB, 1'b1, 1'b0);
        // empty message replays what came before it
        send_request(8'h00, 1'b0, 1'b1);
        // zero code stops the message, later characters are dropped
        send_request(CODE_END, 1'b1, 1'b1);
        send_request(8'h5A, 1'b1, 1'b0);
        send_request(8'h33, 1'b0, 1'b0);
        // fill the line, then one more that must be ignored
        send_request(8'hFF, 1'b1, 1'b1);
        for (int i = 1; i < LINE_W; i++) begin
            send_request((i == 1) ? 8'h01 : (i == 2) ? 8'h80 : 8'(i * 17), 1'b1, 1'b0);
        end
        send_request(8'h42, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);

        productive_requests = 0;
        while (productive_requests < 180) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                end
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 20)
                                                  : $urandom_range(1, 10);
                empty_start = ($urandom_range(0, 9) == 0);
                send_request(random_char(), !empty_start, 1'b1);
                for (int k = 1; k < len; k++) begin
                    send_request(random_char(), 1'b1, 1'b0);
                end
            end
        end

        steady_flow = 1'b0;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // longest start sequence plus slack, so stray nibbles still get caught
        repeat (2 * (2 * (4 + LINE_W) + LINE_W + 1)) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lcdsw_pkg.sv
rtl/lcdsw_line_ram.sv
rtl/lcdsw_nibble_tx.sv
rtl/lcd_two_line_scroll_writer_unit.sv
tb/testbench.sv
